// ===== design/epcal_pkg.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar: shared definitions
// Constants, reciprocals for the constant divisions and month tables used by
// the conversion pipeline.
// ----------------------------------------------------------------------------
package epcal_pkg;

   localparam int EPOCH_W    = 40;
   localparam int PIPE_DEPTH = 11;

   // Seconds are biased by a whole number of days so that the day count is
   // never negative and the day offset to 0000-03-01 is a whole number of
   // 400-year eras (39 of them).
   localparam int     BIAS_ERAS  = 39;
   localparam longint BIAS_DAYS  = 64'd719468 + 64'd146097 * 64'(BIAS_ERAS);
   localparam logic [40:0] SEC_BIAS = 41'(BIAS_DAYS * 64'd86400);

   // Day count comes from (seconds >> 7) / 675 by a reciprocal that is exact
   // for any 34-bit dividend. The product is built from two 17-bit halves.
   localparam int DIV_STAGES = 3;
   localparam int DAY_SHIFT  = 44;
   localparam logic [34:0] DAY_RECIP = 35'((64'd1 << DAY_SHIFT) / 64'd675 + 64'd1);
   localparam logic [9:0]  DIV_675   = 10'd675;

   // Reciprocals for floor division by a constant: (x * RECIP) >> SHIFT.
   localparam int ERA_SHIFT  = 42;
   localparam logic [24:0] ERA_RECIP  = 25'((64'd1 << ERA_SHIFT) / 64'd146097 + 64'd1);
   localparam int HOUR_SHIFT = 20;
   localparam logic [12:0] HOUR_RECIP = 13'((64'd1 << HOUR_SHIFT) / 64'd225 + 64'd1);
   localparam int MIN_SHIFT  = 14;
   localparam logic [10:0] MIN_RECIP  = 11'((64'd1 << MIN_SHIFT) / 64'd15 + 64'd1);
   localparam int Q365_SHIFT = 25;
   localparam logic [16:0] Q365_RECIP = 17'((64'd1 << Q365_SHIFT) / 64'd365 + 64'd1);
   localparam int CENT_SHIFT = 30;
   localparam logic [16:0] CENT_RECIP = 17'((64'd1 << CENT_SHIFT) / 64'd9131 + 64'd1);
   localparam int YOE_SHIFT  = 27;
   localparam logic [18:0] YOE_RECIP  = 19'((64'd1 << YOE_SHIFT) / 64'd365 + 64'd1);
   localparam int Y100_SHIFT = 16;
   localparam logic [9:0]  Y100_RECIP = 10'((64'd1 << Y100_SHIFT) / 64'd100 + 64'd1);
   localparam int MP_SHIFT   = 19;
   localparam logic [11:0] MP_RECIP   = 12'((64'd1 << MP_SHIFT) / 64'd153 + 64'd1);

   localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
   localparam logic [17:0] LAST_DOE     = 18'd146096;
   localparam logic [16:0] YEAR_OFFSET  = 17'(BIAS_ERAS * 400 + 1900);
   localparam logic [3:0]  MP_JANUARY   = 4'd10;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [2:0] wday;
   } hms_type;

   // Days before the first of each month in a common year.
   function automatic logic [8:0] month_start(input logic [3:0] mon);
      logic [8:0] days;
      case (mon)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd59;
         4'd3:    days = 9'd90;
         4'd4:    days = 9'd120;
         4'd5:    days = 9'd151;
         4'd6:    days = 9'd181;
         4'd7:    days = 9'd212;
         4'd8:    days = 9'd243;
         4'd9:    days = 9'd273;
         4'd10:   days = 9'd304;
         4'd11:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   // Days before the first of each month in a year that starts in March.
   function automatic logic [8:0] mar_month_start(input logic [3:0] mp);
      logic [8:0] days;
      case (mp)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd92;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd184;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd245;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd337;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// ===== design/epoch_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar
// Converts signed seconds since 1970-01-01 00:00 UTC into the proleptic
// Gregorian UTC breakdown in a fully pipelined datapath.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and never raises busy. Each
// result appears on the rsp_ ports with rsp_valid high for one cycle, in order
// of acceptance. The pipeline holds four stages of the reciprocal divide by
// 86400 that yields the day count and the second of the day, followed by seven
// stages for the era, year, month, day and time of day. The receiver cannot
// hold results off, so nothing is ever stalled.
module epoch_seconds_to_calendar
   import epcal_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [EPOCH_W-1:0] req_epoch_seconds,
   output logic                      rsp_valid,
   output logic signed [15:0]        rsp_years_since_1900,
   output logic [3:0]                rsp_month_index,
   output logic [4:0]                rsp_day_of_month,
   output logic [4:0]                rsp_hour_of_day,
   output logic [5:0]                rsp_minute_of_hour,
   output logic [5:0]                rsp_second_of_minute,
   output logic [2:0]                rsp_weekday,
   output logic [8:0]                rsp_day_of_year
);

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;

   // Divider stages: the dividend, the two partial products of the reciprocal,
   // the quotient and the remainder, with the low 7 seconds bits alongside.
   logic [33:0] d0_x_ff;
   logic [51:0] d1_phi_ff, d1_phi_in;
   logic [51:0] d1_plo_ff, d1_plo_in;
   logic [9:0]  d1_xl_ff;
   logic [23:0] d2_q_ff, d2_q_in;
   logic [9:0]  d2_xl_ff;
   logic [23:0] d3_q_ff;
   logic [9:0]  d3_r_ff, d3_r_in;
   logic [6:0]  div_low_ff [0:DIV_STAGES];

   logic [40:0] biased_in;

   logic [23:0] e1_dd_ff, e1_dd_in;
   logic [6:0]  e1_era_ff, e1_era_in;
   logic [16:0] e1_sod_ff, e1_sod_in;
   logic [4:0]  e1_hour_ff, e1_hour_in;
   logic [5:0]  e1_wsum_ff, e1_wsum_in;

   logic [17:0] e2_doe_ff, e2_doe_in;
   logic [6:0]  e2_era_ff;
   logic [11:0] e2_remh_ff, e2_remh_in;
   logic [4:0]  e2_hour_ff;
   logic [2:0]  e2_wday_ff, e2_wday_in;

   logic [17:0] e3_n_ff, e3_n_in;
   logic [17:0] e3_doe_ff;
   logic [6:0]  e3_era_ff;
   logic [11:0] e3_remh_ff;
   logic [4:0]  e3_hour_ff;
   logic [5:0]  e3_minute_ff, e3_minute_in;
   logic [2:0]  e3_wday_ff;

   logic [8:0]  e4_yoe_ff, e4_yoe_in;
   logic [17:0] e4_doe_ff;
   logic [6:0]  e4_era_ff;
   hms_type     e4_hms_ff, e4_hms_in;

   logic [8:0]  e5_yoe_ff;
   logic [8:0]  e5_doym_ff, e5_doym_in;
   logic [6:0]  e5_era_ff;
   hms_type     e5_hms_ff;

   logic [8:0]  e6_yoe_ff;
   logic [8:0]  e6_doym_ff;
   logic [3:0]  e6_mp_ff, e6_mp_in;
   logic [6:0]  e6_era_ff;
   hms_type     e6_hms_ff;

   logic signed [15:0] out_year_ff, out_year_in;
   logic [3:0]  out_mon_ff, out_mon_in;
   logic [4:0]  out_mday_ff, out_mday_in;
   logic [8:0]  out_yday_ff, out_yday_in;
   hms_type     out_hms_ff;

   assign busy = 1'b0;

   // ---------------------------------------------------------------- control
   always_comb begin
      valid_in = {valid_ff[PIPE_DEPTH-2:0], start & ~busy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---------------------------------------------------------- day division
   always_comb begin
      logic [68:0] prod;
      biased_in = {req_epoch_seconds[EPOCH_W-1], req_epoch_seconds} + SEC_BIAS;
      d1_phi_in = 52'(d0_x_ff[33:17]) * 52'(DAY_RECIP);
      d1_plo_in = 52'(d0_x_ff[16:0]) * 52'(DAY_RECIP);
      prod      = {d1_phi_ff, 17'd0} + 69'(d1_plo_ff);
      d2_q_in   = prod[DAY_SHIFT +: 24];
      // The remainder is below 675, so ten bits of the difference are enough.
      d3_r_in   = d2_xl_ff - 10'(34'(d2_q_ff) * 34'(DIV_675));
   end

   always_ff @(posedge clock) begin
      d0_x_ff       <= biased_in[40:7];
      div_low_ff[0] <= biased_in[6:0];
      d1_phi_ff     <= d1_phi_in;
      d1_plo_ff     <= d1_plo_in;
      d1_xl_ff      <= d0_x_ff[9:0];
      d2_q_ff       <= d2_q_in;
      d2_xl_ff      <= d1_xl_ff;
      d3_q_ff       <= d2_q_ff;
      d3_r_ff       <= d3_r_in;
      for (int s = 0; s < DIV_STAGES; s++) begin
         div_low_ff[s+1] <= div_low_ff[s];
      end
   end

   // ------------------------------------ era index, hour and weekday digits
   always_comb begin
      logic [48:0] era_prod;
      logic [25:0] hour_prod;
      logic [26:0] wd_arg;
      e1_dd_in   = d3_q_ff;
      e1_sod_in  = {d3_r_ff, div_low_ff[DIV_STAGES]};
      era_prod   = 49'(e1_dd_in) * 49'(ERA_RECIP);
      e1_era_in  = era_prod[ERA_SHIFT +: 7];
      hour_prod  = 26'(e1_sod_in[16:4]) * 26'(HOUR_RECIP);
      e1_hour_in = hour_prod[HOUR_SHIFT +: 5];
      // Eight is one modulo seven, so the octal digits sum to the same residue.
      wd_arg     = 27'(e1_dd_in) + 27'd3;
      e1_wsum_in = '0;
      for (int d = 0; d < 9; d++) begin
         e1_wsum_in = e1_wsum_in + 6'(wd_arg[3*d +: 3]);
      end
   end

   always_ff @(posedge clock) begin
      e1_dd_ff   <= e1_dd_in;
      e1_era_ff  <= e1_era_in;
      e1_sod_ff  <= e1_sod_in;
      e1_hour_ff <= e1_hour_in;
      e1_wsum_ff <= e1_wsum_in;
   end

   // -------------------------------- day of era, rest of hour, weekday fold
   always_comb begin
      logic [3:0] fold1;
      logic [2:0] fold2;
      e2_doe_in  = 18'(e1_dd_ff - 24'(e1_era_ff) * 24'(DAYS_PER_ERA));
      e2_remh_in = 12'(e1_sod_ff - 17'(e1_hour_ff) * 17'd3600);
      fold1      = 4'(e1_wsum_ff[5:3]) + 4'(e1_wsum_ff[2:0]);
      fold2      = 3'(4'(fold1[3]) + 4'(fold1[2:0]));
      e2_wday_in = (fold1[3] == 1'b0 && fold1[2:0] == 3'd7) ? 3'd0 :
                   (fold1[3] == 1'b1 && fold1[2:0] == 3'd6) ? 3'd0 : fold2;
   end

   always_ff @(posedge clock) begin
      e2_doe_ff  <= e2_doe_in;
      e2_era_ff  <= e1_era_ff;
      e2_remh_ff <= e2_remh_in;
      e2_hour_ff <= e1_hour_ff;
      e2_wday_ff <= e2_wday_in;
   end

   // ------------------------------ leap-day correction, minute of the hour
   always_comb begin
      logic [32:0] q4_prod;
      logic [32:0] q100_prod;
      logic [20:0] min_prod;
      q4_prod      = 33'(e2_doe_ff[17:2]) * 33'(Q365_RECIP);
      q100_prod    = 33'(e2_doe_ff[17:2]) * 33'(CENT_RECIP);
      e3_n_in      = e2_doe_ff - 18'(q4_prod[Q365_SHIFT +: 8])
                     + 18'(q100_prod[CENT_SHIFT +: 3])
                     - 18'(e2_doe_ff == LAST_DOE);
      min_prod     = 21'(e2_remh_ff[11:2]) * 21'(MIN_RECIP);
      e3_minute_in = min_prod[MIN_SHIFT +: 6];
   end

   always_ff @(posedge clock) begin
      e3_n_ff      <= e3_n_in;
      e3_doe_ff    <= e2_doe_ff;
      e3_era_ff    <= e2_era_ff;
      e3_remh_ff   <= e2_remh_ff;
      e3_hour_ff   <= e2_hour_ff;
      e3_minute_ff <= e3_minute_in;
      e3_wday_ff   <= e2_wday_ff;
   end

   // ------------------------------------------ year of era, second of minute
   always_comb begin
      logic [36:0] yoe_prod;
      yoe_prod         = 37'(e3_n_ff) * 37'(YOE_RECIP);
      e4_yoe_in        = yoe_prod[YOE_SHIFT +: 9];
      e4_hms_in.hour   = e3_hour_ff;
      e4_hms_in.minute = e3_minute_ff;
      e4_hms_in.second = 6'(e3_remh_ff - 12'(e3_minute_ff) * 12'd60);
      e4_hms_in.wday   = e3_wday_ff;
   end

   always_ff @(posedge clock) begin
      e4_yoe_ff <= e4_yoe_in;
      e4_doe_ff <= e3_doe_ff;
      e4_era_ff <= e3_era_ff;
      e4_hms_ff <= e4_hms_in;
   end

   // ------------------------------------------ day of the March-based year
   always_comb begin
      logic [18:0] cent_prod;
      logic [17:0] year_days;
      cent_prod  = 19'(e4_yoe_ff) * 19'(Y100_RECIP);
      year_days  = 18'(e4_yoe_ff) * 18'd365 + 18'(e4_yoe_ff[8:2])
                   - 18'(cent_prod[Y100_SHIFT +: 3]);
      e5_doym_in = 9'(e4_doe_ff - year_days);
   end

   always_ff @(posedge clock) begin
      e5_yoe_ff  <= e4_yoe_ff;
      e5_doym_ff <= e5_doym_in;
      e5_era_ff  <= e4_era_ff;
      e5_hms_ff  <= e4_hms_ff;
   end

   // --------------------------------------------- month of the March year
   always_comb begin
      logic [10:0] mp_arg;
      logic [22:0] mp_prod;
      mp_arg   = 11'(e5_doym_ff) * 11'd5 + 11'd2;
      mp_prod  = 23'(mp_arg) * 23'(MP_RECIP);
      e6_mp_in = mp_prod[MP_SHIFT +: 4];
   end

   always_ff @(posedge clock) begin
      e6_yoe_ff  <= e5_yoe_ff;
      e6_doym_ff <= e5_doym_ff;
      e6_mp_ff   <= e6_mp_in;
      e6_era_ff  <= e5_era_ff;
      e6_hms_ff  <= e5_hms_ff;
   end

   // ------------------------------------------------------- result register
   always_comb begin
      logic       in_next_year;
      logic [8:0] ym;
      logic       leap;
      in_next_year = (e6_mp_ff >= MP_JANUARY);
      out_mon_in   = in_next_year ? 4'(e6_mp_ff - MP_JANUARY) : 4'(e6_mp_ff + 4'd2);
      out_mday_in  = 5'(e6_doym_ff - mar_month_start(e6_mp_ff) + 9'd1);
      // January and February belong to the next calendar year.
      ym           = e6_yoe_ff + 9'(in_next_year);
      out_year_in  = 16'(17'(e6_era_ff) * 17'd400 + 17'(ym) - YEAR_OFFSET);
      // The year within the 400-year era decides the leap rule by itself.
      leap         = (ym[1:0] == 2'd0) && (ym != 9'd100) && (ym != 9'd200)
                     && (ym != 9'd300);
      out_yday_in  = month_start(out_mon_in) + 9'(out_mday_in) - 9'd1
                     + 9'(leap && !in_next_year);
   end

   always_ff @(posedge clock) begin
      out_year_ff <= out_year_in;
      out_mon_ff  <= out_mon_in;
      out_mday_ff <= out_mday_in;
      out_yday_ff <= out_yday_in;
      out_hms_ff  <= e6_hms_ff;
   end

   assign rsp_valid            = valid_ff[PIPE_DEPTH-1];
   assign rsp_years_since_1900 = out_year_ff;
   assign rsp_month_index      = out_mon_ff;
   assign rsp_day_of_month     = out_mday_ff;
   assign rsp_hour_of_day      = out_hms_ff.hour;
   assign rsp_minute_of_hour   = out_hms_ff.minute;
   assign rsp_second_of_minute = out_hms_ff.second;
   assign rsp_weekday          = out_hms_ff.wday;
   assign rsp_day_of_year      = out_yday_ff;

endmodule
